@@ src/positional_array_list_core_macros.svh @@
// Assertion macros shared by the positional list checker.
`ifndef POSITIONAL_ARRAY_LIST_CORE_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define PAL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define PAL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pal_pkg.sv @@
// Package: types, sizes and codes of the positional array list.
`default_nettype none

package pal_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  // wide enough for first + count, first + position and the 8-bit position
  localparam int CMP_W      = (CNT_W + 1 > 9) ? CNT_W + 1 : 9;

  localparam logic [1:0] OP_QUERY  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic signed [31:0] code;
    logic [63:0]        name;
    logic [31:0]        price;
  } entry_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         position;
    logic signed [31:0] code_in;
    logic [63:0]        name_in;
    logic [31:0]        price_in;
  } list_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] code_out;
    logic [63:0]        name_out;
    logic [31:0]        price_out;
    logic [4:0]         items_now;
  } list_out_t;

  typedef struct packed {
    logic load;   // capture request transaction
    logic exec;   // run operation, update list, load result register
  } dp_cmd_t;

endpackage

`default_nettype wire

@@ src/positional_array_list_core.sv @@
// A request is captured into the request register, then executed into the result register.
// A new request is taken only after the last one executes; all slots shift in parallel.
// The next request is taken while a finished result waits in the output register.
// Reset (rst_ni, async, active low): list empty, first index 0, no result pending.
// Execution stalls while an earlier result has not yet been taken.
`default_nettype none

module positional_array_list_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pal_pkg::list_in_t  in_data_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pal_pkg::list_out_t out_data_o
);
  import pal_pkg::*;

  // command bundle from controller to datapath
  dp_cmd_t cmd;

  // Controller: IDLE takes a request transaction, EXEC runs it once the
  // result register is free or being drained in the same cycle.
  pal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Datapath: request register, the slot cell chain (each cell loads
  // itself, its lower or upper neighbor, or the new entry), first index,
  // count, and the result register that feeds the output channel.
  pal_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

@@ src/pal_ctrl.sv @@
// Controller: sequences capture and execution, owns the result valid flag.
`default_nettype none

module pal_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pal_pkg::dp_cmd_t cmd_o
);
  import pal_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.load  = in_valid_i && (state_q == S_IDLE);
    cmd_o.exec  = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (cmd_o.load) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        // waits here while an older result is still unclaimed
        if (cmd_o.exec) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ src/pal_datapath.sv @@
// Datapath: slot cell chain, first index, count and result register.
`default_nettype none

module pal_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pal_pkg::dp_cmd_t   cmd_i,
  input  pal_pkg::list_in_t  in_data_i,
  output pal_pkg::list_out_t out_data_o
);
  import pal_pkg::*;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LOWER,
    SEL_UPPER,
    SEL_FRESH
  } sel_e;

  list_in_t   req_q;
  list_out_t  res_q, res_d;
  entry_t     slots_q [LIST_DEPTH];
  entry_t     slots_d [LIST_DEPTH];
  entry_t     lo_src  [LIST_DEPTH];
  entry_t     hi_src  [LIST_DEPTH];
  logic [IDX_W-1:0] first_q, first_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [CMP_W-1:0] pos_w, cnt_w, first_w, base_w, rd_w, last_w, at_w, jw;
  logic             rd_ok, ins_ok, full, room, do_ins, do_rem;
  logic [IDX_W-1:0] rd_idx;
  entry_t           rd_entry, fresh;
  sel_e             sel;

  // neighbor taps of each cell; ends tie to themselves and are never selected
  for (genvar j = 0; j < LIST_DEPTH; j++) begin : g_tap
    if (j == 0) begin : g_lo_end
      assign lo_src[j] = slots_q[j];
    end else begin : g_lo
      assign lo_src[j] = slots_q[j-1];
    end
    if (j == LIST_DEPTH - 1) begin : g_hi_end
      assign hi_src[j] = slots_q[j];
    end else begin : g_hi
      assign hi_src[j] = slots_q[j+1];
    end
  end

  always_comb begin
    pos_w   = CMP_W'(req_q.position);
    cnt_w   = CMP_W'(cnt_q);
    first_w = CMP_W'(first_q);
    base_w  = (cnt_q == '0) ? '0 : first_w;
    full    = (cnt_w == CMP_W'(LIST_DEPTH));
    rd_ok   = (pos_w != '0) && (pos_w <= cnt_w);
    ins_ok  = !full && (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1));
    rd_w    = first_w + pos_w - CMP_W'(1);
    last_w  = first_w + cnt_w - CMP_W'(1);
    room    = (base_w + cnt_w) < CMP_W'(LIST_DEPTH);
    // top slot in use: earlier entries move down and first drops by one
    at_w    = room ? (base_w + pos_w - CMP_W'(1)) : (base_w + pos_w - CMP_W'(2));
    rd_idx  = rd_w[IDX_W-1:0];
    rd_entry = slots_q[rd_idx];
    fresh.code  = req_q.code_in;
    fresh.name  = req_q.name_in;
    fresh.price = req_q.price_in;

    do_ins = cmd_i.exec && (req_q.opcode == OP_INSERT) && ins_ok;
    do_rem = cmd_i.exec && (req_q.opcode == OP_REMOVE) && rd_ok;

    for (int j = 0; j < LIST_DEPTH; j++) begin
      jw  = CMP_W'(j);
      sel = SEL_HOLD;
      if (do_ins) begin
        if (jw == at_w) begin
          sel = SEL_FRESH;
        end else if (room && jw > at_w && jw <= base_w + cnt_w) begin
          sel = SEL_LOWER;
        end else if (!room && jw >= base_w - CMP_W'(1) && jw < at_w) begin
          sel = SEL_UPPER;
        end
      end else if (do_rem) begin
        if (jw >= rd_w && jw < last_w) begin
          sel = SEL_UPPER;
        end
      end
      case (sel)
        SEL_LOWER: slots_d[j] = lo_src[j];
        SEL_UPPER: slots_d[j] = hi_src[j];
        SEL_FRESH: slots_d[j] = fresh;
        default:   slots_d[j] = slots_q[j];
      endcase
    end

    first_d = first_q;
    cnt_d   = cnt_q;
    if (do_ins) begin
      first_d = room ? base_w[IDX_W-1:0] : IDX_W'(base_w - CMP_W'(1));
      cnt_d   = cnt_q + CNT_W'(1);
    end else if (do_rem) begin
      cnt_d   = cnt_q - CNT_W'(1);
    end

    res_d           = '0;
    res_d.status    = ST_BADPOS;
    res_d.items_now = 5'(cnt_d);
    case (req_q.opcode)
      OP_QUERY, OP_REMOVE: begin
        if (rd_ok) begin
          res_d.status    = ST_OK;
          res_d.code_out  = rd_entry.code;
          res_d.name_out  = rd_entry.name;
          res_d.price_out = rd_entry.price;
        end
      end
      OP_INSERT: begin
        if (full) begin
          res_d.status = ST_FULL;
        end else if (ins_ok) begin
          res_d.status = ST_OK;
        end
      end
      default: res_d.status = ST_BADPOS;
    endcase
  end

  assign out_data_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      cnt_q   <= '0;
    end else if (cmd_i.exec) begin
      first_q <= first_d;
      cnt_q   <= cnt_d;
    end
  end

  // payload: entries outside the live range are never read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
    if (cmd_i.exec) begin
      res_q   <= res_d;
      slots_q <= slots_d;
    end
  end

endmodule

`default_nettype wire

@@ src/pal_checker.sv @@
// Port-level checker for the positional list core, bound to the top level.
`default_nettype none

`include "positional_array_list_core_macros.svh"

module pal_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input pal_pkg::list_in_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input pal_pkg::list_out_t out_data_o
);
  import pal_pkg::*;

  logic in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  `PAL_ASSERT_NXT(a_in_hold, in_valid_i && !in_ready_o, in_valid_i && $stable(in_data_i), "request dropped or changed while waiting")
  `PAL_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result dropped or changed while stalled")
  `PAL_ASSERT_NXT(a_one_at_a_time, in_fire, !in_ready_o, "request taken while another executes")
  `PAL_ASSERT_IMP(a_exec_gap, $rose(out_valid_o), $past(!in_ready_o), "result without execute cycle")
  `PAL_ASSERT_IMP(a_err_zero, out_valid_o && (out_data_o.status != ST_OK), (out_data_o.code_out == 0) && (out_data_o.name_out == 0) && (out_data_o.price_out == 0), "error result carries payload")

endmodule

bind positional_array_list_core pal_checker u_pal_checker (.*);

`default_nettype wire
